// File: rtl/core/cfc_pkg.sv
`timescale 1ns / 1ps

package cfc_pkg;

	// Fixed field widths of one word
	localparam int CH_BITS     = 4;
	localparam int SETTLE_BITS = 16;

	// Action codes
	localparam logic ACT_CHECK = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	// One input word
	typedef struct packed {
		logic                   action;
		logic [CH_BITS-1:0]     channel;
		logic                   commanded_on;
		logic                   on_sensor;
		logic                   off_sensor;
		logic [SETTLE_BITS-1:0] on_settle;
		logic [SETTLE_BITS-1:0] off_settle;
	} item_t;

	// Control from the pipeline to the channel state file
	typedef struct packed {
		logic  en;
		item_t item;
	} step_t;

endpackage

// File: rtl/core/cfc_chan_state.sv
`timescale 1ns / 1ps

module cfc_chan_state
	import cfc_pkg::*;
#(
	parameter int CHANNELS   = 16,
	parameter int TIMER_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  step_t step,
	output logic  fault
);

	localparam int IDX_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int LOAD_BITS = (TIMER_BITS > SETTLE_BITS) ? TIMER_BITS : SETTLE_BITS;
	localparam logic [TIMER_BITS-1:0] TMR_MAX = '1;

	logic                  last_q  [CHANNELS];
	logic                  armed_q [CHANNELS];
	logic [TIMER_BITS-1:0] timer_q [CHANNELS];

	logic                  is_tick;
	logic                  is_check;
	logic                  ch_ok;
	logic [IDX_BITS-1:0]   idx;
	logic                  cur_last;
	logic                  cur_armed;
	logic [TIMER_BITS-1:0] cur_timer;
	logic [SETTLE_BITS-1:0] settle;
	logic [LOAD_BITS-1:0]  load_w;
	logic [TIMER_BITS-1:0] load;
	logic                  chg;
	logic [TIMER_BITS-1:0] timer_new;
	logic                  armed_new;
	logic                  expire;

	assign is_tick  = step.en && (step.item.action == ACT_TICK);
	assign is_check = step.en && (step.item.action == ACT_CHECK);
	assign ch_ok    = 32'(step.item.channel) < CHANNELS;
	assign idx      = IDX_BITS'(step.item.channel);

	always_comb begin
		cur_last  = 1'b0;
		cur_armed = 1'b0;
		cur_timer = '0;
		if (ch_ok) begin
			cur_last  = last_q[idx];
			cur_armed = armed_q[idx];
			cur_timer = timer_q[idx];
		end
	end

	// saturate the settle load to the timer width
	assign settle = step.item.commanded_on ? step.item.off_settle : step.item.on_settle;
	assign load_w = LOAD_BITS'(settle);
	assign load   = (load_w > LOAD_BITS'(TMR_MAX)) ? TMR_MAX : load_w[TIMER_BITS-1:0];

	assign chg       = step.item.commanded_on != cur_last;
	assign timer_new = chg ? load : cur_timer;
	assign armed_new = chg || cur_armed;
	assign expire    = armed_new && (timer_new == '0);

	assign fault = ch_ok && expire &&
		(step.item.commanded_on ? step.item.off_sensor : step.item.on_sensor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_q[i]  <= 1'b0;
				armed_q[i] <= 1'b0;
				timer_q[i] <= '0;
			end
		end else if (is_tick) begin
			// decrement every running timer
			for (int i = 0; i < CHANNELS; i++) begin
				if (timer_q[i] != '0) begin
					timer_q[i] <= timer_q[i] - 1'b1;
				end
			end
		end else if (is_check && ch_ok) begin
			last_q[idx]  <= step.item.commanded_on;
			armed_q[idx] <= armed_new && !expire;
			timer_q[idx] <= timer_new;
		end
	end

endmodule

// File: rtl/core/cylinder_feedback_timeout_check_core.sv
`timescale 1ns / 1ps
// A check word is registered in the input stage, and its result then in the result register.
// Throughput: one word per cycle while the result is not stalled; a tick word yields no result.
// The per-channel state update sets the rate: channel state lives in flops.
// Reset (arst_n low) clears all commands, armed flags, timers and both valid stages.
// Input stall rises only while the input stage holds a check word and the result is stalled.

module cylinder_feedback_timeout_check_core
	import cfc_pkg::*;
#(
	parameter int CHANNELS   = 16,
	parameter int TIMER_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   action,
	input  logic [CH_BITS-1:0]     channel,
	input  logic                   commanded_on,
	input  logic                   on_sensor,
	input  logic                   off_sensor,
	input  logic [SETTLE_BITS-1:0] on_settle,
	input  logic [SETTLE_BITS-1:0] off_settle,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   fault,
	output logic [CH_BITS-1:0]     fault_channel
);

	// Input stage: one registered word waiting for the state update
	logic  vld_s1;
	item_t item_s1;

	// Result register
	logic               out_vld_q;
	logic               fault_q;
	logic [CH_BITS-1:0] fault_ch_q;

	logic  out_free;
	logic  adv;
	logic  adv_check;
	logic  take;
	logic  fault_c;
	step_t step;

	// The result slot is free when empty or being taken this cycle
	assign out_free  = !out_vld_q || !out_stall;
	// A tick never needs the result slot, so it always advances
	assign adv       = vld_s1 && ((item_s1.action == ACT_TICK) || out_free);
	assign adv_check = adv && (item_s1.action == ACT_CHECK);
	assign in_stall  = vld_s1 && !adv;
	assign take      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// Hold the payload while stalled, load on accept
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action       <= action;
			item_s1.channel      <= channel;
			item_s1.commanded_on <= commanded_on;
			item_s1.on_sensor    <= on_sensor;
			item_s1.off_sensor   <= off_sensor;
			item_s1.on_settle    <= on_settle;
			item_s1.off_settle   <= off_settle;
		end
	end

	// Channel state file: evaluates the word and commits its update on advance
	assign step.en   = adv;
	assign step.item = item_s1;

	cfc_chan_state #(
		.CHANNELS   (CHANNELS),
		.TIMER_BITS (TIMER_BITS)
	) u_chan_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.fault  (fault_c)
	);

	// Result register: fill on a check advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_check) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_check) begin
			fault_q    <= fault_c;
			fault_ch_q <= item_s1.channel;
		end
	end

	assign out_valid     = out_vld_q;
	assign fault         = fault_q;
	assign fault_channel = fault_ch_q;

	// A new result only ever follows a check word leaving the input stage
	a_rise_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(adv_check))
		else $error("result appeared without a check word");

	// Input side stalls only while a word is held
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1)
		else $error("input stalled with empty stage");

	// An out-of-range channel never reports a fault
	a_range_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (32'(fault_ch_q) >= CHANNELS)) |-> !fault_q)
		else $error("fault on channel beyond range");

endmodule
